// ===== hdl/levels_gamma_pixel_map_defines.svh =====
// Assertion macros for the levels and gamma pixel map.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef LEVELS_GAMMA_PIXEL_MAP_DEFINES_SVH
`define LEVELS_GAMMA_PIXEL_MAP_DEFINES_SVH

`define LGPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define LGPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LGPM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hdl/lgpm_pkg.sv =====
`timescale 1ns / 1ps
package lgpm_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned GAMMA_W    = 12;
  localparam int unsigned POINT_W    = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [GAMMA_W-1:0] GAMMA_MIN = 12'd26;
  localparam logic [GAMMA_W-1:0] GAMMA_MAX = 12'd2560;
  localparam logic [POINT_W-1:0] POINT_MAX = 13'd4096;

  localparam logic [GAMMA_W-1:0] GAMMA_RST     = 12'd256;
  localparam logic [POINT_W-1:0] IN_BLACK_RST  = 13'd0;
  localparam logic [POINT_W-1:0] IN_WHITE_RST  = 13'd4096;
  localparam logic [POINT_W-1:0] OUT_BLACK_RST = 13'd0;
  localparam logic [POINT_W-1:0] OUT_WHITE_RST = 13'd4096;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Default quotient bits resolved per divider stage
  localparam int unsigned DIV_BPS = 3;

  localparam int unsigned DEN_W     = 20;  // 255 * (white - black)
  localparam int unsigned V_W       = 17;  // Q0.16 plus the value 1.0
  localparam int unsigned MANT_W    = 31;  // Q1.30 log mantissa
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned LOG_W     = 21;  // Q5.16 log magnitude
  localparam int unsigned T_W       = 25;  // scaled exponent, Q9.16
  localparam int unsigned ACC_W     = 31;  // Q1.30 exp accumulator
  localparam int unsigned FACT_W    = 30;
  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned EXP_STEPS = 16;
  localparam int unsigned PROD_W    = 30;

  localparam logic [V_W-1:0] V_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAMMA     = 3'd0,
    CFG_IN_BLACK  = 3'd1,
    CFG_IN_WHITE  = 3'd2,
    CFG_OUT_BLACK = 3'd3,
    CFG_OUT_WHITE = 3'd4
  } cfg_reg_e;

  // Normalized value pinned at an end of the range
  typedef struct packed {
    logic zero;
    logic full;
  } range_t;

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] xv;
    res   = '0;
    bit_v = 64'd1 << 62;
    xv    = x;
    for (int i = 0; i < 32; i++) begin
      if (xv >= res + bit_v) begin
        xv  = xv - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-k) in Q0.30 by repeated square roots of 0.5
  function automatic logic [FACT_W-1:0] exp_factor(int unsigned k);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int unsigned j = 1; j <= EXP_STEPS; j++) begin
      if (j <= k) begin
        c = isqrt64(c << 30);
      end
    end
    return c[FACT_W-1:0];
  endfunction

endpackage

// ===== hdl/levels_gamma_pixel_map.sv =====
// Levels adjustment with midtone gamma, one 8-bit pixel per beat.
// Pipeline: 39 + ceil(17/B) + ceil(25/B) register stages, B = DIV_BITS_PER_STAGE
// (54 stages at B = 3).
// Throughput: one pixel per cycle; the whole pipeline holds while the output beat waits.
// Reset: asynchronous, active low; clears all valid bits and loads the default
// levels setup (gamma 1.0, full input and output range).
`timescale 1ns / 1ps
module levels_gamma_pixel_map #(
  parameter int unsigned DIV_BITS_PER_STAGE = lgpm_pkg::DIV_BPS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] pixel_out
  output logic                              m_axis_tuser,   // [0] setup_invalid
  input  logic                              cfg_we_i,
  input  logic [lgpm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lgpm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned GW = lgpm_pkg::GAMMA_W;
  localparam int unsigned PW = lgpm_pkg::POINT_W;
  localparam int unsigned DW = lgpm_pkg::DEN_W;
  localparam int unsigned VW = lgpm_pkg::V_W;
  localparam int unsigned RW = $bits(lgpm_pkg::range_t);

  logic [GW-1:0] gamma_q;
  logic [PW-1:0] in_black_q;
  logic [PW-1:0] in_white_q;
  logic [PW-1:0] out_black_q;
  logic [PW-1:0] out_white_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q     <= lgpm_pkg::GAMMA_RST;
      in_black_q  <= lgpm_pkg::IN_BLACK_RST;
      in_white_q  <= lgpm_pkg::IN_WHITE_RST;
      out_black_q <= lgpm_pkg::OUT_BLACK_RST;
      out_white_q <= lgpm_pkg::OUT_WHITE_RST;
    end else if (cfg_we_i) begin
      unique case (lgpm_pkg::cfg_reg_e'(cfg_index_i))
        lgpm_pkg::CFG_GAMMA:     gamma_q     <= cfg_wdata_i[GW-1:0];
        lgpm_pkg::CFG_IN_BLACK:  in_black_q  <= cfg_wdata_i[PW-1:0];
        lgpm_pkg::CFG_IN_WHITE:  in_white_q  <= cfg_wdata_i[PW-1:0];
        lgpm_pkg::CFG_OUT_BLACK: out_black_q <= cfg_wdata_i[PW-1:0];
        lgpm_pkg::CFG_OUT_WHITE: out_white_q <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;

  // Advance every stage whenever the output register is free or being taken
  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  // Input register
  logic                            in_vld_q;
  logic [lgpm_pkg::PIX_W-1:0]      pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q <= s_axis_tdata;
    end
  end

  // Normalize: num = pix*4096 - 255*in_black against den = 255*(white - black)
  logic [20:0]        blk255;
  logic [PW-1:0]      span;
  logic [20:0]        den_w;
  logic [DW-1:0]      den;
  logic signed [21:0] num;
  logic [36:0]        dividend;
  lgpm_pkg::range_t   rng1_d;

  assign blk255   = {in_black_q, 8'h00} - 21'(in_black_q);
  assign span     = in_white_q - in_black_q;
  assign den_w    = {span, 8'h00} - 21'(span);
  assign den      = den_w[DW-1:0];
  assign num      = $signed({2'b00, pix_q, 12'h000}) - $signed({1'b0, blk255});
  assign dividend = {1'b0, num[19:0], 16'h0000} + 37'(den[DW-1:1]);

  always_comb begin
    rng1_d.zero = num[21] | (num == '0);
    rng1_d.full = ~rng1_d.zero & (num[20:0] >= {1'b0, den});
  end

  logic              s1_vld_q;
  lgpm_pkg::range_t  s1_rng_q;
  logic [DW-1:0]     s1_rem_q;
  logic [VW-1:0]     s1_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_rng_q <= rng1_d;
      s1_rem_q <= dividend[36:17];
      s1_low_q <= dividend[16:0];
    end
  end

  logic          nrm_vld;
  logic [VW-1:0] nrm_v;
  logic [RW-1:0] nrm_side;

  lgpm_div #(
    .DIV_W  (DW),
    .QUO_W  (VW),
    .SIDE_W (RW),
    .BPS    (DIV_BITS_PER_STAGE)
  ) u_lgpm_div_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s1_vld_q),
    .rem_i     (s1_rem_q),
    .low_i     (s1_low_q),
    .divisor_i (den),
    .side_i    (s1_rng_q),
    .valid_o   (nrm_vld),
    .quo_o     (nrm_v),
    .side_o    (nrm_side)
  );

  logic                        log_vld;
  logic [lgpm_pkg::LOG_W-1:0]  log_d;
  lgpm_pkg::range_t            log_rng;

  lgpm_log u_lgpm_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nrm_vld),
    .v_i     (nrm_v),
    .rng_i   (lgpm_pkg::range_t'(nrm_side)),
    .valid_o (log_vld),
    .d_o     (log_d),
    .rng_o   (log_rng)
  );

  // Scale: t = round(d * 256 / gamma)
  logic [28:0]               scaled;
  logic                      sc_vld;
  logic [lgpm_pkg::T_W-1:0]  sc_t;
  logic [RW-1:0]             sc_side;

  assign scaled = {log_d, 8'h00} + 29'(gamma_q[GW-1:1]);

  lgpm_div #(
    .DIV_W  (GW),
    .QUO_W  (lgpm_pkg::T_W),
    .SIDE_W (RW),
    .BPS    (DIV_BITS_PER_STAGE)
  ) u_lgpm_div_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (log_vld),
    .rem_i     (GW'(scaled[28:25])),
    .low_i     (scaled[24:0]),
    .divisor_i (gamma_q),
    .side_i    (log_rng),
    .valid_o   (sc_vld),
    .quo_o     (sc_t),
    .side_o    (sc_side)
  );

  logic          exp_vld;
  logic [VW-1:0] exp_p;

  lgpm_exp u_lgpm_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sc_vld),
    .t_i     (sc_t),
    .rng_i   (lgpm_pkg::range_t'(sc_side)),
    .valid_o (exp_vld),
    .p_o     (exp_p)
  );

  // Output range map: out_black*(1-p) + out_white*p
  logic                          mul_vld_q;
  logic [lgpm_pkg::PROD_W-1:0]   prod_b_q;
  logic [lgpm_pkg::PROD_W-1:0]   prod_w_q;
  logic [VW-1:0]                 p_inv;

  assign p_inv = lgpm_pkg::V_ONE - exp_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= exp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_b_q <= lgpm_pkg::PROD_W'(out_black_q) * lgpm_pkg::PROD_W'(p_inv);
      prod_w_q <= lgpm_pkg::PROD_W'(out_white_q) * lgpm_pkg::PROD_W'(exp_p);
    end
  end

  logic [30:0]                sum;
  logic [38:0]                sum255;
  logic [38:0]                rounded;
  logic [10:0]                level;
  logic                       setup_bad;
  logic [lgpm_pkg::PIX_W-1:0] pix_d;

  assign sum     = 31'(prod_b_q) + 31'(prod_w_q);
  assign sum255  = {sum, 8'h00} - 39'(sum);
  assign rounded = sum255 + (39'd1 << 27);
  assign level   = rounded[38:28];

  assign setup_bad = (gamma_q < lgpm_pkg::GAMMA_MIN) || (gamma_q > lgpm_pkg::GAMMA_MAX) ||
                     (in_black_q > lgpm_pkg::POINT_MAX) || (in_white_q > lgpm_pkg::POINT_MAX) ||
                     (out_black_q > lgpm_pkg::POINT_MAX) ||
                     (out_white_q > lgpm_pkg::POINT_MAX) || (in_black_q >= in_white_q);

  always_comb begin
    priority if (setup_bad) begin
      pix_d = '0;
    end else if (level > 11'(lgpm_pkg::PIX_MAX)) begin
      pix_d = lgpm_pkg::PIX_MAX;
    end else begin
      pix_d = level[lgpm_pkg::PIX_W-1:0];
    end
  end

  logic [lgpm_pkg::PIX_W-1:0] out_pix_q;
  logic                       out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q <= pix_d;
      out_bad_q <= setup_bad;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

// ===== hdl/lgpm_div.sv =====
`timescale 1ns / 1ps
module lgpm_div #(
  parameter int unsigned DIV_W  = 20,
  parameter int unsigned QUO_W  = 17,
  parameter int unsigned SIDE_W = 2,
  parameter int unsigned BPS    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [QUO_W-1:0]  low_i,
  input  logic [DIV_W-1:0]  divisor_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned STAGES = (QUO_W + BPS - 1) / BPS;

  logic              vld_q  [STAGES];
  logic [DIV_W-1:0]  rem_q  [STAGES];
  logic [QUO_W-1:0]  low_q  [STAGES];
  logic [QUO_W-1:0]  quo_q  [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic              vld_src;
    logic [DIV_W-1:0]  rem_src;
    logic [QUO_W-1:0]  low_src;
    logic [QUO_W-1:0]  quo_src;
    logic [SIDE_W-1:0] side_src;
    logic [DIV_W-1:0]  rem_d;
    logic [QUO_W-1:0]  low_d;
    logic [QUO_W-1:0]  quo_d;

    if (s == 0) begin : g_first
      assign vld_src  = valid_i;
      assign rem_src  = rem_i;
      assign low_src  = low_i;
      assign quo_src  = '0;
      assign side_src = side_i;
    end else begin : g_next
      assign vld_src  = vld_q[s-1];
      assign rem_src  = rem_q[s-1];
      assign low_src  = low_q[s-1];
      assign quo_src  = quo_q[s-1];
      assign side_src = side_q[s-1];
    end

    // Restoring division, one quotient bit per step
    always_comb begin
      logic [DIV_W:0] trial;
      logic [DIV_W:0] diff;
      rem_d = rem_src;
      low_d = low_src;
      quo_d = quo_src;
      for (int unsigned b = 0; b < BPS; b++) begin
        if (s * BPS + b < QUO_W) begin
          trial = {rem_d, low_d[QUO_W-1]};
          diff  = trial - {1'b0, divisor_i};
          low_d = low_d << 1;
          if (trial >= {1'b0, divisor_i}) begin
            rem_d = diff[DIV_W-1:0];
            quo_d = {quo_d[QUO_W-2:0], 1'b1};
          end else begin
            rem_d = trial[DIV_W-1:0];
            quo_d = {quo_d[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        low_q[s]  <= low_d;
        quo_q[s]  <= quo_d;
        side_q[s] <= side_src;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign quo_o   = quo_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

// ===== hdl/lgpm_log.sv =====
`timescale 1ns / 1ps
module lgpm_log (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [lgpm_pkg::V_W-1:0]     v_i,
  input  lgpm_pkg::range_t             rng_i,
  output logic                         valid_o,
  output logic [lgpm_pkg::LOG_W-1:0]   d_o,
  output lgpm_pkg::range_t             rng_o
);

  localparam int unsigned N  = lgpm_pkg::LOG_STEPS;
  localparam int unsigned MW = lgpm_pkg::MANT_W;
  localparam int unsigned FW = lgpm_pkg::FRAC_W;

  logic                 vld_q  [N+1];
  lgpm_pkg::range_t     rng_q  [N+1];
  logic [3:0]           e_q    [N+1];
  logic [MW-1:0]        m_q    [N+1];
  logic [FW-1:0]        frac_q [N+1];

  lgpm_pkg::range_t rng_d;
  logic [3:0]       e_d;
  logic [MW-1:0]    m_d;

  // Classify the ends and normalize the mantissa to [1, 2)
  always_comb begin
    rng_d.zero = rng_i.zero | (~rng_i.full & (v_i == '0));
    rng_d.full = rng_i.full | (~rng_i.zero & v_i[lgpm_pkg::V_W-1]);
    e_d = '0;
    for (int i = 0; i < FW; i++) begin
      if (v_i[i]) begin
        e_d = 4'(i);
      end
    end
    m_d = MW'(v_i[FW-1:0]) << (5'd30 - {1'b0, e_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rng_q[0]  <= rng_d;
      e_q[0]    <= e_d;
      m_q[0]    <= m_d;
      frac_q[0] <= '0;
    end
  end

  // One squaring per stage yields one fraction bit
  for (genvar k = 1; k <= N; k++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     top;
    logic [MW-1:0]   m_next;
    logic            fbit;

    assign sq     = (2*MW)'(m_q[k-1]) * (2*MW)'(m_q[k-1]);
    assign top    = sq[2*MW-1:MW-1];
    assign fbit   = top[MW];
    assign m_next = fbit ? top[MW:1] : top[MW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rng_q[k]  <= rng_q[k-1];
        e_q[k]    <= e_q[k-1];
        m_q[k]    <= m_next;
        frac_q[k] <= {frac_q[k-1][FW-2:0], fbit};
      end
    end
  end

  logic                         out_vld_q;
  logic [lgpm_pkg::LOG_W-1:0]   d_q;
  lgpm_pkg::range_t             out_rng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q       <= {5'd16 - {1'b0, e_q[N]}, FW'(0)} - lgpm_pkg::LOG_W'(frac_q[N]);
      out_rng_q <= rng_q[N];
    end
  end

  assign valid_o = out_vld_q;
  assign d_o     = d_q;
  assign rng_o   = out_rng_q;

endmodule

// ===== hdl/lgpm_exp.sv =====
`timescale 1ns / 1ps
module lgpm_exp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [lgpm_pkg::T_W-1:0]   t_i,
  input  lgpm_pkg::range_t           rng_i,
  output logic                       valid_o,
  output logic [lgpm_pkg::V_W-1:0]   p_o
);

  localparam int unsigned N  = lgpm_pkg::EXP_STEPS;
  localparam int unsigned AW = lgpm_pkg::ACC_W;
  localparam int unsigned CW = lgpm_pkg::FACT_W;
  localparam int unsigned FW = lgpm_pkg::FRAC_W;
  localparam int unsigned NW = lgpm_pkg::T_W - lgpm_pkg::FRAC_W;

  logic              vld_q [N];
  lgpm_pkg::range_t  rng_q [N];
  logic [AW-1:0]     acc_q [N];
  logic [FW-1:0]     f_q   [N];
  logic [NW-1:0]     n_q   [N];

  // Stage s multiplies in 2^-(2^-(s+1)) when that fraction bit is set
  for (genvar s = 0; s < N; s++) begin : g_mul
    localparam logic [CW-1:0] FACTOR = lgpm_pkg::exp_factor(s + 1);
    logic              vld_src;
    lgpm_pkg::range_t  rng_src;
    logic [AW-1:0]     acc_src;
    logic [FW-1:0]     f_src;
    logic [NW-1:0]     n_src;
    logic [AW+CW-1:0]  prod;

    if (s == 0) begin : g_first
      assign vld_src = valid_i;
      assign rng_src = rng_i;
      assign acc_src = AW'(1) << 30;
      assign f_src   = t_i[FW-1:0];
      assign n_src   = t_i[lgpm_pkg::T_W-1:FW];
    end else begin : g_next
      assign vld_src = vld_q[s-1];
      assign rng_src = rng_q[s-1];
      assign acc_src = acc_q[s-1];
      assign f_src   = f_q[s-1];
      assign n_src   = n_q[s-1];
    end

    assign prod = (AW+CW)'(acc_src) * (AW+CW)'(FACTOR);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rng_q[s] <= rng_src;
        acc_q[s] <= f_src[FW-1-s] ? prod[AW+CW-1:CW] : acc_src;
        f_q[s]   <= f_src;
        n_q[s]   <= n_src;
      end
    end
  end

  logic [lgpm_pkg::V_W-1:0] p_d;
  logic [31:0]              rnd_sum;
  logic [31:0]              shifted;

  // Apply the integer part as a rounded right shift
  always_comb begin
    rnd_sum = 32'(acc_q[N-1]) + (32'd1 << (5'd13 + n_q[N-1][4:0]));
    shifted = rnd_sum >> (5'd14 + n_q[N-1][4:0]);
    priority if (rng_q[N-1].zero) begin
      p_d = '0;
    end else if (rng_q[N-1].full) begin
      p_d = lgpm_pkg::V_ONE;
    end else if (n_q[N-1] > NW'(16)) begin
      p_d = '0;
    end else if (shifted > 32'(lgpm_pkg::V_ONE)) begin
      p_d = lgpm_pkg::V_ONE;
    end else begin
      p_d = shifted[lgpm_pkg::V_W-1:0];
    end
  end

  logic                     out_vld_q;
  logic [lgpm_pkg::V_W-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign valid_o = out_vld_q;
  assign p_o     = p_q;

endmodule

// ===== hdl/lgpm_checker.sv =====
`timescale 1ns / 1ps
`include "levels_gamma_pixel_map_defines.svh"
module lgpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  // A held output beat keeps its payload
  `LGPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

  // A stalled output must stop intake
  `LGPM_ASSERT(a_back_pressure, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input accepted while output stalled")

  // An unusable setup always reads as black
  `LGPM_ASSERT(a_bad_setup_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00, "flagged beat carries nonzero pixel")

endmodule

bind levels_gamma_pixel_map lgpm_checker u_lgpm_checker (.*);
